[design/signed_decimal_field_formatter_defines.svh]
// assertion macros shared by the formatter checker
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_DEFINES_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SDFF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdff assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define SDFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdff assertion failed");

`endif

[design/sdff_pkg.sv]
// shared constants and control types of the signed decimal field formatter
package sdff_pkg;

  localparam int VALUE_W        = 32;
  localparam int CHAR_W         = 8;
  localparam int FW_W           = 7;
  localparam int DIGIT_W        = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_DIGITS_DEF = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PAD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_JUSTIFY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH  = 2'd2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

  typedef struct packed {
    logic start;
    logic shift;
  } sdff_ctrl_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] top_digit;
  } sdff_stat_t;

endpackage

[design/sdff_b2d.sv]
// bit-serial binary to bcd converter with leading zero strip and digit shift-out
module sdff_b2d #(
  parameter int MAX_DIGITS = sdff_pkg::MAX_DIGITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sdff_pkg::sdff_ctrl_t                   ctrl_i,
  input  logic [sdff_pkg::VALUE_W-1:0]           mag_i,
  output sdff_pkg::sdff_stat_t                   stat_o,
  output logic [$clog2(MAX_DIGITS+1)-1:0]        ndig_o
);
  import sdff_pkg::*;

  localparam int D4     = MAX_DIGITS * DIGIT_W;
  localparam int BC_W   = $clog2(VALUE_W + 1);
  localparam int NDIG_W = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_SHIFT = 2'd1;
  localparam logic [1:0] B_NORM  = 2'd2;

  logic [1:0]         st_q, st_d;
  logic [BC_W-1:0]    cnt_q, cnt_d;
  logic [NDIG_W-1:0]  ndig_q, ndig_d;
  logic [D4-1:0]      bcd_q, bcd_d, adj;
  logic [VALUE_W-1:0] mag_q, mag_d;
  logic               done;
  logic [DIGIT_W-1:0] top;

  assign top = bcd_q[D4-1 -: DIGIT_W];

  // add three to every digit of five or more before each shift
  always_comb begin
    logic [DIGIT_W-1:0] dg;
    dg = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dg = bcd_q[i*DIGIT_W +: DIGIT_W];
      adj[i*DIGIT_W +: DIGIT_W] = (dg >= DIGIT_W'(5)) ? dg + DIGIT_W'(3) : dg;
    end
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    ndig_d = ndig_q;
    bcd_d  = bcd_q;
    mag_d  = mag_q;
    done   = 1'b0;
    case (st_q)
      B_IDLE: begin
        if (ctrl_i.start) begin
          mag_d = mag_i;
          bcd_d = '0;
          cnt_d = BC_W'(VALUE_W);
          st_d  = B_SHIFT;
        end else if (ctrl_i.shift) begin
          bcd_d = {bcd_q[D4-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
      end
      B_SHIFT: begin
        bcd_d = {adj[D4-2:0], mag_q[VALUE_W-1]};
        mag_d = {mag_q[VALUE_W-2:0], 1'b0};
        cnt_d = cnt_q - BC_W'(1);
        if (cnt_q == BC_W'(1)) begin
          ndig_d = NDIG_W'(MAX_DIGITS);
          st_d   = B_NORM;
        end
      end
      B_NORM: begin
        if (top == '0 && ndig_q > NDIG_W'(1)) begin
          bcd_d  = {bcd_q[D4-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          ndig_d = ndig_q - NDIG_W'(1);
        end else begin
          done = 1'b1;
          st_d = B_IDLE;
        end
      end
      default: begin
        st_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_IDLE;
      cnt_q  <= '0;
      ndig_q <= '0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      ndig_q <= ndig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    mag_q <= mag_d;
  end

  assign stat_o.done      = done;
  assign stat_o.top_digit = top;
  assign ndig_o           = ndig_q;

endmodule

[design/signed_decimal_field_formatter.sv]
// per value: the bit-serial double dabble conversion, the leading zero strip, a handoff to the
// character state machine, then the characters in order, each held while the output stalls;
// one value at a time; a new value is taken once the last character of the previous one is loaded
// rst_ni clears the flags, the width and all control state at once; no clearing pass
// top level: signed decimal formatter with field width padding on stream ports
module signed_decimal_field_formatter #(
  parameter int MAX_WIDTH  = sdff_pkg::MAX_WIDTH_DEF,
  parameter int MAX_DIGITS = sdff_pkg::MAX_DIGITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sdff_pkg::VALUE_W-1:0]     s_axis_tdata,   // value
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sdff_pkg::CHAR_W-1:0]      m_axis_tdata,   // char_out
  output logic                             m_axis_tlast,
  input  logic                             cfg_we_i,
  input  logic [sdff_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sdff_pkg::FW_W-1:0]        cfg_data_i
);
  import sdff_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int CW     = (CNT_W > FW_W) ? CNT_W : FW_W;
  localparam int NDIG_W = $clog2(MAX_DIGITS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SIGN  = 3'd2;
  localparam logic [2:0] S_ZERO  = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;
  localparam logic [2:0] S_SPACE = 3'd5;

  logic              zp_q, lj_q;
  logic [FW_W-1:0]   fw_q;
  logic [2:0]        st_q, st_d;
  logic              neg_q, neg_d;
  logic [CW-1:0]     pad_q, pad_d;
  logic [NDIG_W-1:0] dig_q, dig_d;
  logic              m_valid_q, m_valid_d;
  logic [CHAR_W-1:0] m_data_q, m_data_d;
  logic              m_last_q, m_last_d;

  sdff_ctrl_t        ctrl;
  sdff_stat_t        stat;
  logic [NDIG_W-1:0] ndig;
  logic [VALUE_W-1:0] mag;
  logic              s_acc, adv;
  logic [CW-1:0]     fw_ext, width_c, text_len, pad_calc;

  assign s_axis_tready = (st_q == S_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign adv   = !m_valid_q || m_axis_tready;
  assign mag   = s_axis_tdata[VALUE_W-1] ? (~s_axis_tdata + VALUE_W'(1)) : s_axis_tdata;

  assign fw_ext   = CW'(fw_q);
  assign width_c  = (fw_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : fw_ext;
  assign text_len = CW'(neg_q) + CW'(ndig);
  assign pad_calc = (width_c > text_len && (zp_q || lj_q)) ? width_c - text_len : '0;

  sdff_b2d #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_b2d (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .mag_i (mag),
    .stat_o(stat),
    .ndig_o(ndig)
  );

  always_comb begin
    st_d       = st_q;
    neg_d      = neg_q;
    pad_d      = pad_q;
    dig_d      = dig_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;
    ctrl.start = 1'b0;
    ctrl.shift = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (s_acc) begin
          neg_d      = s_axis_tdata[VALUE_W-1];
          ctrl.start = 1'b1;
          st_d       = S_CONV;
        end
      end
      S_CONV: begin
        if (stat.done) begin
          pad_d = pad_calc;
          dig_d = ndig;
          if (neg_q) begin
            st_d = S_SIGN;
          end else if (pad_calc != '0 && !lj_q) begin
            st_d = S_ZERO;
          end else begin
            st_d = S_DIGIT;
          end
        end
      end
      S_SIGN: begin
        if (adv) begin
          m_valid_d = 1'b1;
          m_data_d  = ASCII_MINUS;
          m_last_d  = 1'b0;
          st_d      = (pad_q != '0 && !lj_q) ? S_ZERO : S_DIGIT;
        end
      end
      S_ZERO: begin
        if (adv) begin
          m_valid_d = 1'b1;
          m_data_d  = ASCII_ZERO;
          m_last_d  = 1'b0;
          pad_d     = pad_q - CW'(1);
          if (pad_q == CW'(1)) begin
            st_d = S_DIGIT;
          end
        end
      end
      S_DIGIT: begin
        if (adv) begin
          m_valid_d  = 1'b1;
          m_data_d   = ASCII_ZERO + CHAR_W'(stat.top_digit);
          m_last_d   = 1'b0;
          ctrl.shift = 1'b1;
          dig_d      = dig_q - NDIG_W'(1);
          if (dig_q == NDIG_W'(1)) begin
            if (lj_q && pad_q != '0) begin
              st_d = S_SPACE;
            end else begin
              m_last_d = 1'b1;
              st_d     = S_IDLE;
            end
          end
        end
      end
      S_SPACE: begin
        if (adv) begin
          m_valid_d = 1'b1;
          m_data_d  = ASCII_SPACE;
          m_last_d  = 1'b0;
          pad_d     = pad_q - CW'(1);
          if (pad_q == CW'(1)) begin
            m_last_d = 1'b1;
            st_d     = S_IDLE;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zp_q      <= 1'b0;
      lj_q      <= 1'b0;
      fw_q      <= '0;
      st_q      <= S_IDLE;
      neg_q     <= 1'b0;
      pad_q     <= '0;
      dig_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ZERO_PAD:     zp_q <= cfg_data_i[0];
          CFG_LEFT_JUSTIFY: lj_q <= cfg_data_i[0];
          CFG_FIELD_WIDTH:  fw_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      st_q      <= st_d;
      neg_q     <= neg_d;
      pad_q     <= pad_d;
      dig_q     <= dig_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

[design/sdff_chk.sv]
// port-level checker for the signed decimal field formatter, bound to the top level
`include "signed_decimal_field_formatter_defines.svh"

module sdff_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sdff_pkg::CHAR_W-1:0]    m_axis_tdata,
  input logic                           m_axis_tlast
);
  import sdff_pkg::*;

  logic s_acc, char_ok;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign char_ok = (m_axis_tdata == ASCII_MINUS) || (m_axis_tdata == ASCII_SPACE) ||
                   (m_axis_tdata[7:4] == 4'h3 && m_axis_tdata[3:0] <= 4'd9);

  // stalled output transaction holds its character and marker
  `SDFF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  // one value at a time
  `SDFF_ASSERT_NEXT(a_in_busy, s_acc, !s_axis_tready)
  // no character appears right after a value is accepted while the output was empty
  `SDFF_ASSERT_NEXT(a_conv_gap, s_acc && !m_axis_tvalid, !m_axis_tvalid)
  // only sign, digits and spaces come out
  `SDFF_ASSERT_NOW(a_char_set, m_axis_tvalid, char_ok)

endmodule

bind signed_decimal_field_formatter sdff_chk u_sdff_chk (.*);

[bench/signed_decimal_field_formatter_tb.sv]
// testbench for the signed decimal field formatter: predicted ascii text checked per character
`timescale 1ns / 100ps

module signed_decimal_field_formatter_tb;
  import sdff_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int MISMATCH_PRINT_MAX = 40;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [VALUE_W-1:0]   s_axis_tdata = '0;    // value
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [CHAR_W-1:0]    m_axis_tdata;         // char_out
  logic                 m_axis_tlast;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [FW_W-1:0]      cfg_data_i = '0;

  logic            fmt_zero_pad = 1'b0;
  logic            fmt_left = 1'b0;
  logic [FW_W-1:0] fmt_width = '0;

  text_char_t expected_chars[$];

  int src_idle_pct = 35;
  int sink_idle_pct = 35;
  int sink_hold_cycles = 0;
  int mismatch_count = 0;
  int values_sent = 0;
  int chars_checked = 0;
  int format_changes = 0;

  signed_decimal_field_formatter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < MISMATCH_PRINT_MAX) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // expected text of one value under the current format
  function automatic void predict_text(input logic [VALUE_W-1:0] v);
    logic              neg;
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digs[MAX_DIGITS_DEF];
    logic [CHAR_W-1:0] text[$];
    int                nd;
    int                w;
    int                text_len;
    int                pad;
    text_char_t        tc;
    neg = v[VALUE_W-1];
    mag = neg ? (~v + 1'b1) : v;
    nd = 0;
    do begin
      digs[nd] = DIGIT_W'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0);
    w = (int'(fmt_width) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(fmt_width);
    text_len = nd + (neg ? 1 : 0);
    pad = (w > text_len && (fmt_zero_pad || fmt_left)) ? w - text_len : 0;
    if (neg) text.push_back(ASCII_MINUS);
    if (!fmt_left) begin
      repeat (pad) text.push_back(ASCII_ZERO);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      text.push_back(ASCII_ZERO + CHAR_W'(digs[i]));
    end
    if (fmt_left) begin
      repeat (pad) text.push_back(ASCII_SPACE);
    end
    foreach (text[i]) begin
      tc.ch = text[i];
      tc.last = (i == text.size() - 1);
      expected_chars.push_back(tc);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    longint unsigned span;
    logic [VALUE_W-1:0] v;
    span = 1;
    case ($urandom_range(7))
      0: v = $urandom;
      1: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          default: v = '0;
        endcase
      end
      default: begin
        repeat ($urandom_range(1, 10)) span = span * 10;
        v = 32'(longint'($urandom) % span);
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
    endcase
    return v;
  endfunction

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_text(v);
    values_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FW_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_ZERO_PAD:     fmt_zero_pad = data[0];
      CFG_LEFT_JUSTIFY: fmt_left = data[0];
      CFG_FIELD_WIDTH:  fmt_width = data;
      default: ;
    endcase
  endtask

  // flag writes carry random upper bits, only bit 0 counts
  task automatic set_format(input logic zp, input logic lj, input int fw);
    logic [FW_W-2:0] junk_a;
    logic [FW_W-2:0] junk_b;
    junk_a = (FW_W-1)'($urandom);
    junk_b = (FW_W-1)'($urandom);
    wait_idle();
    write_reg(CFG_ZERO_PAD, {junk_a, zp});
    write_reg(CFG_LEFT_JUSTIFY, {junk_b, lj});
    write_reg(CFG_FIELD_WIDTH, FW_W'(fw));
    format_changes++;
  endtask

  task automatic test_reset_defaults();
    send_value(32'd0);
    send_value(32'hffff_ffff);
    send_value(32'd7);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    // width alone pads nothing
    set_format(1'b0, 1'b0, 40);
    send_value(32'd31);
  endtask

  task automatic test_zero_pad();
    set_format(1'b1, 1'b0, 12);
    send_value(32'd0);
    send_value(-32'sd5);
    send_value(32'h8000_0000);
    send_value(32'd123456789);
    set_format(1'b1, 1'b0, MAX_WIDTH_DEF);
    send_value(32'hffff_ffff);
  endtask

  task automatic test_left_justify();
    set_format(1'b0, 1'b1, 20);
    send_value(32'd0);
    send_value(-32'sd42);
    send_value(32'h7fff_ffff);
    // left justify wins over zero pad
    set_format(1'b1, 1'b1, 8);
    send_value(-32'sd7);
    send_value(32'd99);
  endtask

  task automatic test_width_limits();
    set_format(1'b1, 1'b0, 3);
    send_value(32'h8000_0000);
    send_value(32'd12345);
    set_format(1'b0, 1'b1, 0);
    send_value(32'd5);
    set_format(1'b1, 1'b0, 127);
    send_value(-32'sd3);
    set_format(1'b0, 1'b1, 65);
    send_value(32'd8);
  endtask

  task automatic test_unused_register();
    set_format(1'b1, 1'b0, 9);
    write_reg(CFG_UNUSED_IDX, 7'h7f);
    send_value(-32'sd12);
    wait_idle();
    write_reg(CFG_UNUSED_IDX, 7'h00);
    send_value(32'd4);
  endtask

  task automatic random_width(output int fw);
    case ($urandom_range(9))
      0: fw = 0;
      1: fw = MAX_WIDTH_DEF;
      2: fw = $urandom_range(MAX_WIDTH_DEF + 1, 127);
      default: fw = $urandom_range(0, 24);
    endcase
  endtask

  task automatic test_random_formats(input int phases);
    int fw;
    for (int p = 0; p < phases; p++) begin
      random_width(fw);
      set_format(1'($urandom_range(1)), 1'($urandom_range(1)), fw);
      repeat ($urandom_range(15, 30)) send_value(random_value());
    end
  endtask

  task automatic test_no_idle();
    int fw;
    random_width(fw);
    set_format(1'($urandom_range(1)), 1'($urandom_range(1)), fw);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    repeat (40) send_value(random_value());
    wait_idle();
    src_idle_pct = 35;
    sink_idle_pct = 35;
  endtask

  task automatic test_output_backpressure();
    set_format(1'b0, 1'b1, 30);
    sink_hold_cycles = 300;
    repeat (6) send_value(random_value());
  endtask

  task automatic test_sender_pause();
    set_format(1'b1, 1'b0, 16);
    repeat (3) begin
      repeat (7) send_value(random_value());
      wait_idle();
    end
  endtask

  // receiver: random stalls, or a long hold-off counted down here
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_chars
    text_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last %b",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        want = expected_chars.pop_front();
        if (m_axis_tdata !== want.ch) begin
          report_mismatch($sformatf("char %0d: got 0x%02h expected 0x%02h",
                                    chars_checked, m_axis_tdata, want.ch));
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch($sformatf("char %0d: tlast got %b expected %b",
                                    chars_checked, m_axis_tlast, want.last));
        end
      end
      chars_checked++;
    end
  end

  initial begin
    #5_000_000;
    $display("signed_decimal_field_formatter_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_zero_pad();
    test_left_justify();
    test_width_limits();
    test_unused_register();
    test_random_formats(13);
    test_no_idle();
    test_output_backpressure();
    test_sender_pause();
    wait_idle();
    repeat (80) @(negedge clk_i);
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
    end
    $display("run covered %0d values, %0d characters, %0d format settings, %0d mismatches",
             values_sent, chars_checked, format_changes, mismatch_count);
    $display("including sign and width extremes, output hold-off and sender pauses");
    if (mismatch_count == 0) begin
      $display("signed_decimal_field_formatter_tb: PASS");
    end else begin
      $display("signed_decimal_field_formatter_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/sdff_pkg.sv
design/sdff_b2d.sv
design/signed_decimal_field_formatter.sv
design/sdff_chk.sv
bench/signed_decimal_field_formatter_tb.sv
